@@ hdl/dbcs_pkg.sv @@
package dbcs_pkg;

   // byte classes
   localparam logic [7:0] LEAD_MIN   = 8'h80;
   localparam logic [7:0] ASCII_LO   = 8'h20;
   localparam logic [7:0] ASCII_MID  = 8'h5F;
   localparam logic [7:0] ASCII_HI   = 8'h7F;
   localparam logic [7:0] NEWLINE    = 8'h0A;

   // full-width code mapping
   localparam logic [7:0] CODE_LOW   = 8'hA3;
   localparam logic [7:0] HIGH_LO    = 8'h20;
   localparam logic [7:0] HIGH_HI    = 8'h21;

   // advance code for a line break
   localparam logic signed [8:0] ADV_NEWLINE = -9'sd1;

   // register map
   localparam int unsigned ADDR_W = 4;
   typedef enum logic [1:0] {
      REG_FONT_LOADED = 2'd0,
      REG_FONT_WIDTH  = 2'd1,
      REG_FONT_HEIGHT = 2'd2
   } reg_index_type;

   localparam logic [7:0] FONT_WIDTH_RST  = 8'd16;
   localparam logic [7:0] FONT_HEIGHT_RST = 8'd16;

   typedef struct packed {
      logic       font_loaded;
      logic [7:0] font_width;
      logic [7:0] font_height;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         text_byte;
      logic               first_of_string;
      logic               last_of_string;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic               follow_x;
      logic               follow_y;
      logic [31:0]        text_color;
      logic [14:0]        wrap_width;
   } req_item_type;

   typedef struct packed {
      logic               show;
      logic [15:0]        glyph_code;
      logic signed [15:0] glyph_x;
      logic signed [15:0] glyph_y;
      logic [31:0]        glyph_color;
   } glyph_type;

   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/dbcs_if.sv @@
interface dbcs_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         text_byte;
   logic               first_of_string;
   logic               last_of_string;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;
   logic               follow_x;
   logic               follow_y;
   logic [31:0]        text_color;
   logic [14:0]        wrap_width;

   modport source (
      output valid, text_byte, first_of_string, last_of_string, start_x, start_y,
             follow_x, follow_y, text_color, wrap_width,
      input  ready
   );
   modport sink (
      input  valid, text_byte, first_of_string, last_of_string, start_x, start_y,
             follow_x, follow_y, text_color, wrap_width,
      output ready
   );
endinterface

interface dbcs_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        glyph_code;
   logic signed [15:0] glyph_x;
   logic signed [15:0] glyph_y;
   logic [31:0]        glyph_color;

   modport source (
      output valid, glyph_code, glyph_x, glyph_y, glyph_color,
      input  ready
   );
   modport sink (
      input  valid, glyph_code, glyph_x, glyph_y, glyph_color,
      output ready
   );
endinterface

@@ hdl/dbcs_csr.sv @@
module dbcs_csr
   import dbcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic       font_loaded_ff, font_loaded_in;
   logic [7:0] font_width_ff, font_width_in;
   logic [7:0] font_height_ff, font_height_in;
   logic       wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[3:2]);

   always_comb begin
      font_loaded_in = font_loaded_ff;
      font_width_in  = font_width_ff;
      font_height_in = font_height_ff;
      prdata         = '0;
      case (idx)
         REG_FONT_LOADED: begin
            prdata = {31'd0, font_loaded_ff};
            if (wr_en) font_loaded_in = pwdata[0];
         end
         REG_FONT_WIDTH: begin
            prdata = {24'd0, font_width_ff};
            if (wr_en) font_width_in = pwdata[7:0];
         end
         REG_FONT_HEIGHT: begin
            prdata = {24'd0, font_height_ff};
            if (wr_en) font_height_in = pwdata[7:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_loaded_ff <= 1'b0;
         font_width_ff  <= FONT_WIDTH_RST;
         font_height_ff <= FONT_HEIGHT_RST;
      end else begin
         font_loaded_ff <= font_loaded_in;
         font_width_ff  <= font_width_in;
         font_height_ff <= font_height_in;
      end
   end

   assign cfg = '{font_loaded: font_loaded_ff, font_width: font_width_ff,
                  font_height: font_height_ff};

endmodule

@@ hdl/dbcs_engine.sv @@
module dbcs_engine
   import dbcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         step_en,
   input  req_item_type item,
   output glyph_type    glyph
);

   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] pen_offset_ff, pen_offset_in;
   logic signed [15:0] pen_y_ff, pen_y_in;
   logic signed [8:0]  last_adv_ff, last_adv_in;
   logic [7:0]         lead_byte_ff, lead_byte_in;
   logic               lead_pending_ff, lead_pending_in;
   logic               skip_nl_ff, skip_nl_in;
   logic [31:0]        color_ff, color_in;
   logic [14:0]        wrap_ff, wrap_in;

   // state as seen after the start-of-string update
   logic signed [15:0] cur_origin, cur_off, cur_y;
   logic signed [8:0]  cur_last;
   logic               cur_pending, cur_skip;
   logic [31:0]        cur_color;
   logic [14:0]        cur_wrap, wrap_eff;
   logic [8:0]         twice_fw;

   logic [7:0]         b;
   logic               show;
   logic [15:0]        code;
   logic signed [8:0]  adv;
   logic               brk;
   logic               wrap_hit;
   logic               update;

   assign b        = item.text_byte;
   assign twice_fw = {cfg.font_width, 1'b0};
   assign wrap_eff = (item.wrap_width < {6'd0, twice_fw}) ? '0 : item.wrap_width;
   assign update   = step_en && cfg.font_loaded;

   always_comb begin
      if (item.first_of_string) begin
         cur_origin  = item.follow_x ?
                       sat16({origin_x_ff[15], origin_x_ff} + {pen_offset_ff[15], pen_offset_ff})
                       : item.start_x;
         cur_y       = item.follow_y ? pen_y_ff : item.start_y;
         cur_off     = '0;
         cur_last    = '0;
         cur_pending = 1'b0;
         cur_skip    = 1'b0;
         cur_color   = item.text_color;
         cur_wrap    = wrap_eff;
      end else begin
         cur_origin  = origin_x_ff;
         cur_y       = pen_y_ff;
         cur_off     = pen_offset_ff;
         cur_last    = last_adv_ff;
         cur_pending = lead_pending_ff;
         cur_skip    = skip_nl_ff;
         cur_color   = color_ff;
         cur_wrap    = wrap_ff;
      end
   end

   always_comb begin
      origin_x_in     = cur_origin;
      pen_offset_in   = cur_off;
      pen_y_in        = cur_y;
      last_adv_in     = cur_last;
      lead_byte_in    = lead_byte_ff;
      lead_pending_in = cur_pending;
      skip_nl_in      = 1'b0;
      color_in        = cur_color;
      wrap_in         = cur_wrap;
      show            = 1'b0;
      code            = '0;
      adv             = cur_last;
      brk             = 1'b0;
      wrap_hit        = (cur_wrap != '0) &&
                        ($signed({cur_off[15], cur_off}) > $signed({2'b00, cur_wrap}));

      if (cur_skip && (b == NEWLINE)) begin
         // newline right after a wrap is swallowed
      end else if (!cur_pending && (b > LEAD_MIN) && !item.last_of_string) begin
         lead_byte_in    = b;
         lead_pending_in = 1'b1;
      end else begin
         if (cur_pending) begin
            lead_pending_in = 1'b0;
            code = {b, lead_byte_ff};
            show = 1'b1;
            adv  = {1'b0, cfg.font_width};
         end else if ((b > ASCII_LO) && (b < ASCII_MID)) begin
            code = {8'(HIGH_LO + b), CODE_LOW};
            show = 1'b1;
            adv  = {2'b00, cfg.font_width[7:1]};
         end else if ((b >= ASCII_MID) && (b < ASCII_HI)) begin
            code = {8'(HIGH_HI + b), CODE_LOW};
            show = 1'b1;
            adv  = {2'b00, cfg.font_width[7:1]};
         end else if (b == NEWLINE) begin
            adv = ADV_NEWLINE;
         end
         last_adv_in = adv;
         brk = (adv == ADV_NEWLINE) || wrap_hit;
         if (brk) begin
            skip_nl_in    = (adv != ADV_NEWLINE);
            pen_offset_in = '0;
            pen_y_in      = sat16({cur_y[15], cur_y} + {9'd0, cfg.font_height});
         end else begin
            pen_offset_in = sat16({cur_off[15], cur_off} + {{8{adv[8]}}, adv});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         pen_offset_ff   <= '0;
         pen_y_ff        <= '0;
         last_adv_ff     <= '0;
         lead_byte_ff    <= '0;
         lead_pending_ff <= 1'b0;
         skip_nl_ff      <= 1'b0;
         color_ff        <= '0;
         wrap_ff         <= '0;
      end else if (update) begin
         origin_x_ff     <= origin_x_in;
         pen_offset_ff   <= pen_offset_in;
         pen_y_ff        <= pen_y_in;
         last_adv_ff     <= last_adv_in;
         lead_byte_ff    <= lead_byte_in;
         lead_pending_ff <= lead_pending_in;
         skip_nl_ff      <= skip_nl_in;
         color_ff        <= color_in;
         wrap_ff         <= wrap_in;
      end
   end

   assign glyph = '{show:        show && cfg.font_loaded,
                    glyph_code:  code,
                    glyph_x:     sat16({cur_origin[15], cur_origin} + {cur_off[15], cur_off}),
                    glyph_y:     cur_y,
                    glyph_color: cur_color};

endmodule

@@ hdl/dbcs_text_layout.sv @@
// double-byte text layout: takes one string byte per transfer on req_ch and gives one glyph
// per visible character on rsp_ch (code, pen position, color); lead bytes, newlines, control
// bytes and newlines swallowed after an auto wrap give no glyph; the block takes one byte every
// clock cycle with no gaps as long as rsp_ch keeps up; a stalled glyph holds the byte behind it
// in the input register, and the input stalls once both registers are full; a closing byte goes
// through the input register, then the step logic, then the result register, from which its glyph
// is offered on rsp_ch; font registers sit on the apb port at 0x0 (loaded), 0x4 (width), 0x8
// (height) and are to be written only while the block is idle: the user is bound by this, and
// the block itself does not enforce it; with the font not loaded bytes are taken and dropped
// without touching the pen state
module dbcs_text_layout
   import dbcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   dbcs_req_if.sink          req_ch,
   dbcs_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type      cfg;
   glyph_type    glyph;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type item_ff, item_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        code_ff, code_in;
   logic signed [15:0] gx_ff, gx_in;
   logic signed [15:0] gy_ff, gy_in;
   logic [31:0]        color_ff, color_in;

   logic advance;
   logic req_fire;

   dbcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dbcs_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (item_ff),
      .glyph   (glyph)
   );

   // the held byte moves on once the result register is free or being emptied
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         item_in = '{text_byte:       req_ch.text_byte,
                     first_of_string: req_ch.first_of_string,
                     last_of_string:  req_ch.last_of_string,
                     start_x:         req_ch.start_x,
                     start_y:         req_ch.start_y,
                     follow_x:        req_ch.follow_x,
                     follow_y:        req_ch.follow_y,
                     text_color:      req_ch.text_color,
                     wrap_width:      req_ch.wrap_width};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      color_in     = color_ff;
      if (advance) begin
         // a byte without a glyph simply leaves the result register empty
         rsp_valid_in = glyph.show;
         if (glyph.show) begin
            code_in  = glyph.glyph_code;
            gx_in    = glyph.glyph_x;
            gy_in    = glyph.glyph_y;
            color_in = glyph.glyph_color;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      code_ff  <= code_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      color_ff <= color_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.glyph_code  = code_ff;
   assign rsp_ch.glyph_x     = gx_ff;
   assign rsp_ch.glyph_y     = gy_ff;
   assign rsp_ch.glyph_color = color_ff;

endmodule
